// ----- rtl/csvt_pkg.sv -----
// Shared constants, types and helpers of the CSV field tokenizer.
package csvt_pkg;

    localparam int PEND_DEPTH = 16;
    localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    localparam int APB_AW = 3;

    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] CR_CH    = 8'h0D;
    localparam logic [7:0] LF_CH    = 8'h0A;
    localparam logic [7:0] NUL_CH   = 8'h00;
    localparam logic [7:0] SPACE_CH = 8'h20;
    localparam logic [7:0] HT_CH    = 8'h09;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    localparam logic REG_DELIM = 1'b0;
    localparam logic REG_TRIM  = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } kind_t;

    // One queued word: held whitespace to replay, then one final result.
    typedef struct packed {
        logic [CNT_W-1:0] flush_cnt;
        logic [7:0]       data;
        kind_t            kind;
        logic             ovf;
    } cmd_t;

    typedef struct packed {
        logic [7:0] delim;
        logic       trim;
    } cfg_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE_CH) || ((c >= HT_CH) && (c <= CR_CH));
    endfunction

endpackage

// ----- rtl/csvt_if.sv -----
// Valid/ready channel interfaces for the tokenizer's input and output words.
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
    logic       overflow;

    modport source (output valid, output out_byte, output kind, output last,
                    output overflow, input ready);
    modport sink   (input valid, input out_byte, input kind, input last,
                    input overflow, output ready);
endinterface

// ----- rtl/csvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module csvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/csvt_fifo.sv -----
// Two-entry queue of decoded words between the front and back parts.
module csvt_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csvt_pkg::cmd_t       wdata,
    input  logic                 pop,
    output csvt_pkg::cmd_t       rdata,
    output logic                 full,
    output logic                 empty
);
    import csvt_pkg::*;

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/csvt_front.sv -----
// Front part: accepts line bytes, tracks quoting and trimming, fills the whitespace buffer.
module csvt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    csvt_in_if.sink                       in_ch,
    input  csvt_pkg::cfg_t                cfg,
    input  logic                          q_full,
    input  logic                          flush_done,
    output logic                          push,
    output csvt_pkg::cmd_t                cmd,
    output logic                          wr_en,
    output logic [csvt_pkg::PEND_AW-1:0]  wr_addr,
    output logic [7:0]                    wr_data
);
    import csvt_pkg::*;

    logic             iq_reg, iq_next;
    logic             qp_reg, qp_next;
    logic             stop_reg, stop_next;
    logic             fne_reg, fne_next;
    logic             cs_reg, cs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             busy_reg, busy_next;

    logic       accept;
    logic       emit;
    logic       wr_req;
    logic       do_unq;
    logic       do_acc;
    logic [7:0] c;

    // While held whitespace is being replayed the buffer must not be refilled.
    assign in_ch.ready = !busy_reg && !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && emit;
    assign wr_en       = accept && wr_req;
    assign wr_addr     = cnt_reg[PEND_AW-1:0];
    assign wr_data     = c;
    assign c           = in_ch.in_byte;

    always_comb
    begin
        iq_next   = iq_reg;
        qp_next   = qp_reg;
        stop_next = stop_reg;
        fne_next  = fne_reg;
        cs_next   = cs_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        emit      = 1'b0;
        wr_req    = 1'b0;
        do_unq    = 1'b0;
        do_acc    = 1'b0;
        cmd.flush_cnt = '0;
        cmd.data      = '0;
        cmd.kind      = KIND_BYTE;

        if (in_ch.action == ACT_EOL)
        begin
            emit      = 1'b1;
            cmd.kind  = KIND_RECORD;
            iq_next   = 1'b0;
            qp_next   = 1'b0;
            stop_next = 1'b0;
            fne_next  = 1'b0;
            cs_next   = 1'b0;
            cnt_next  = '0;
        end
        else if (!stop_reg)
        begin
            if (c == NUL_CH)
            begin
                stop_next = 1'b1;
                qp_next   = 1'b0;
                iq_next   = 1'b0;
            end
            else if (qp_reg)
            begin
                qp_next = 1'b0;
                if (c == QUOTE_CH)
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    iq_next = 1'b0;
                    do_unq  = 1'b1;
                end
            end
            else if (iq_reg)
            begin
                if (c == QUOTE_CH)
                begin
                    qp_next = 1'b1;
                end
                else
                begin
                    do_acc = 1'b1;
                end
            end
            else
            begin
                do_unq = 1'b1;
            end

            if (do_unq)
            begin
                if (!fne_reg && (c == QUOTE_CH))
                begin
                    iq_next = 1'b1;
                end
                else if (c == cfg.delim)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_FIELD;
                    fne_next = 1'b0;
                    cs_next  = 1'b0;
                    cnt_next = '0;
                end
                else if ((c == CR_CH) || (c == LF_CH))
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    do_acc = 1'b1;
                end
            end

            if (do_acc)
            begin
                fne_next = 1'b1;
                if (cfg.trim && is_blank(c))
                begin
                    if (cs_reg)
                    begin
                        if (cnt_reg >= CNT_W'(PEND_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_req   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    emit          = 1'b1;
                    cmd.kind      = KIND_BYTE;
                    cmd.data      = c;
                    cmd.flush_cnt = cnt_reg;
                    cnt_next      = '0;
                    cs_next       = 1'b1;
                end
            end
        end
        cmd.ovf = ovf_next;

        busy_next = (busy_reg && !flush_done) || (push && (cmd.flush_cnt != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iq_reg   <= 1'b0;
            qp_reg   <= 1'b0;
            stop_reg <= 1'b0;
            fne_reg  <= 1'b0;
            cs_reg   <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                iq_reg   <= iq_next;
                qp_reg   <= qp_next;
                stop_reg <= stop_next;
                fne_reg  <= fne_next;
                cs_reg   <= cs_next;
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

endmodule

// ----- rtl/csvt_back.sv -----
// Back part: replays held whitespace from the buffer, then delivers each word's final result.
module csvt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csvt_pkg::cmd_t                head,
    input  logic                          head_valid,
    output logic                          pop,
    output logic                          rd_en,
    output logic [csvt_pkg::PEND_AW-1:0]  rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          flush_done,
    csvt_out_if.source                    out_ch
);
    import csvt_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FLUSH,
        B_FINAL
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_inc;
    logic             ov_reg, ov_next;
    logic [7:0]       ob_reg, ob_next;
    kind_t            ok_reg, ok_next;
    logic             ol_reg, ol_next;
    logic             of_reg, of_next;
    logic             out_free;
    logic             load;

    assign out_free = !ov_reg || out_ch.ready;
    assign idx_inc  = idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ob_next    = ob_reg;
        ok_next    = ok_reg;
        ol_next    = ol_reg;
        of_next    = of_reg;
        load       = 1'b0;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_inc[PEND_AW-1:0];
        flush_done = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.flush_cnt != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = B_FLUSH;
                    end
                    else if (out_free)
                    begin
                        load    = 1'b1;
                        pop     = 1'b1;
                        ob_next = head.data;
                        ok_next = head.kind;
                        ol_next = 1'b1;
                        of_next = head.ovf;
                    end
                end
            end
            B_FLUSH:
            begin
                // Read data for idx_reg is waiting; the next read goes out as it leaves.
                if (out_free)
                begin
                    load     = 1'b1;
                    ob_next  = rd_data;
                    ok_next  = KIND_BYTE;
                    ol_next  = 1'b0;
                    of_next  = head.ovf;
                    idx_next = idx_inc;
                    if (idx_inc < head.flush_cnt)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = B_FINAL;
                    end
                end
            end
            B_FINAL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    pop        = 1'b1;
                    flush_done = 1'b1;
                    ob_next    = head.data;
                    ok_next    = head.kind;
                    ol_next    = 1'b1;
                    of_next    = head.ovf;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            ob_reg    <= '0;
            ok_reg    <= KIND_BYTE;
            ol_reg    <= 1'b0;
            of_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            ob_reg    <= ob_next;
            ok_reg    <= ok_next;
            ol_reg    <= ol_next;
            of_reg    <= of_next;
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.out_byte = ob_reg;
    assign out_ch.kind     = ok_reg;
    assign out_ch.last     = ol_reg;
    assign out_ch.overflow = of_reg;

endmodule

// ----- rtl/csv_field_tokenizer.sv -----
// CSV field tokenizer: one line byte per word in, field bytes and field/record markers out.
// Without back-pressure, an input word that releases no held whitespace is taken every
// cycle, and its result words leave through a registered output one per cycle. A content
// byte that follows n whitespace bytes held by trimming produces n+1 results, paced by the
// single registered read port of the whitespace buffer; the input stalls until that replay
// finishes. Register 0 (byte address 0) is the delimiter, register 1 (byte address 4) the
// trim enable; the user must write both only while the block is idle, unchecked by the block.
module csv_field_tokenizer (
    input  logic                        clk,
    input  logic                        rst_n,
    csvt_in_if.sink                     in_ch,
    csvt_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csvt_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import csvt_pkg::*;

    logic [7:0]         delim_reg;
    logic               trim_reg;
    cfg_t               cfg;
    logic               cfg_wr;

    cmd_t               q_wdata;
    cmd_t               q_rdata;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic               flush_done;

    logic               wr_en;
    logic [PEND_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [PEND_AW-1:0] rd_addr;
    logic [7:0]         rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
            trim_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DELIM: delim_reg <= pwdata[7:0];
                REG_TRIM:  trim_reg  <= pwdata[0];
                default:   delim_reg <= delim_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DELIM: prdata = {24'd0, delim_reg};
            REG_TRIM:  prdata = {31'd0, trim_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.delim = delim_reg;
    assign cfg.trim  = trim_reg;

    csvt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .q_full     (q_full),
        .flush_done (flush_done),
        .push       (q_push),
        .cmd        (q_wdata),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    csvt_ram #(
        .WIDTH (8),
        .DEPTH (PEND_DEPTH)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csvt_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    csvt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_rdata),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .flush_done (flush_done),
        .out_ch     (out_ch)
    );

endmodule

// ----- rtl/csvt_checker.sv -----
// Port-level assertions for the tokenizer and the bind that attaches them.
module csvt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] kind,
    input logic       last,
    input logic       overflow
);
    import csvt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(kind)
                                    && $stable(last) && $stable(overflow))
        else $error("output word changed while stalled");

    // A marker always closes the results of its input word.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_BYTE) |-> last)
        else $error("marker word is not the last result");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_BYTE) |-> (out_byte == 8'd0)
                                             && ((kind == KIND_FIELD) || (kind == KIND_RECORD)))
        else $error("marker word carries a byte or a bad kind");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .kind      (out_ch.kind),
    .last      (out_ch.last),
    .overflow  (out_ch.overflow)
);
